// ----- design/mrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mrc_pkg;

  localparam int MaxRegions = 32;

  // widths of the input fields
  localparam int SlotW  = 5;
  localparam int AddrW  = 64;
  localparam int TypeW  = 8;
  localparam int AttrW  = 32;
  localparam int MaskW  = 32;
  localparam int CountW = 6;

  // cell index width, and the width used to compare index, slot and count
  localparam int IdxW = $clog2(MaxRegions + 1);
  localparam int CmpW = (IdxW > CountW) ? IdxW : CountW;
  localparam int TypeSelW = $clog2(MaskW);

  // packed stream words
  localparam int InDataW  = ((SlotW + 2 * AddrW + TypeW + AttrW + MaskW + 7) / 8) * 8;
  localparam int OutDataW = 8;

  // func codes
  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  // word travelling down the row of cells
  typedef struct packed {
    logic              query;
    logic [SlotW-1:0]  slot;
    logic [AddrW-1:0]  base;
    logic [AddrW-1:0]  lim;        // base + size, valid when ok
    logic              ok;         // span valid (and count in range for a query)
    logic [MaskW-1:0]  type_bits;  // one-hot region type, zero for large types
    logic [AttrW-1:0]  attrs;
    logic [MaskW-1:0]  mask;
    logic              hit;
  } item_t;

endpackage

`default_nettype wire

// ----- design/mrc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mrc_cell (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       adv,
  input  wire  [mrc_pkg::IdxW-1:0]  idx,
  input  wire  [mrc_pkg::CountW-1:0] region_count,
  input  wire                       in_valid,
  input  mrc_pkg::item_t            in_item,
  output logic                      out_valid,
  output mrc_pkg::item_t            out_item
);

  // stored region entry
  logic                          entry_ok;
  logic [mrc_pkg::AddrW-1:0]     entry_base;
  logic [mrc_pkg::AddrW-1:0]     entry_end;
  logic [mrc_pkg::MaskW-1:0]     entry_type_bits;
  logic [mrc_pkg::AttrW-1:0]     entry_attrs;

  logic           slot_sel;
  logic           in_range;
  logic           type_ok;
  logic           attr_ok;
  logic           cover_ok;
  logic           hit_next;
  mrc_pkg::item_t item_next;

  assign slot_sel = mrc_pkg::CmpW'(in_item.slot) == mrc_pkg::CmpW'(idx);
  assign in_range = mrc_pkg::CmpW'(idx) < mrc_pkg::CmpW'(region_count);
  assign type_ok  = (in_item.mask == '0) || ((in_item.mask & entry_type_bits) != '0);
  assign attr_ok  = (entry_attrs & in_item.attrs) == in_item.attrs;
  assign cover_ok = (in_item.base >= entry_base) && (in_item.lim <= entry_end);

  assign hit_next = in_item.hit | (in_item.query & in_item.ok & entry_ok & in_range &
                                   type_ok & attr_ok & cover_ok);

  always_comb begin
    item_next     = in_item;
    item_next.hit = hit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      entry_ok  <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
      if (in_valid && !in_item.query && slot_sel) begin
        entry_ok <= in_item.ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= item_next;
      if (in_valid && !in_item.query && slot_sel) begin
        entry_base      <= in_item.base;
        entry_end       <= in_item.lim;
        entry_type_bits <= in_item.type_bits;
        entry_attrs     <= in_item.attrs;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/memory_region_cover_check_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// memory region cover check: a table of MaxRegions region entries (base, size,
// type, attribute bits) lives in a row of identical cells, one entry per cell.
// every input word walks down the row one cell per cycle: a write word drops
// its entry into the cell whose index equals its slot (slots past the table
// are acknowledged and dropped), a query word collects a hit flag from every
// cell whose valid entry covers [base, base+size), allows the region type
// through the type mask (mask zero allows any type) and carries all required
// attribute bits. words keep their order along the row, so a query sees
// exactly the writes accepted before it. a new word is taken every cycle unless
// the row stalls, which it does while the output word waits to be taken. one
// front stage forms base+size and the range checks, then there is one stage per
// cell, the last cell being the output register. region_count must be written
// through cfg_wen/cfg_wdata only while no word is in flight (not enforced by
// the block); all entries start invalid after reset; no clearing pass is needed
module memory_region_cover_check_core (
  input  wire                           clk,
  input  wire                           rst,
  // configuration: region_count
  input  wire                           cfg_wen,
  input  wire  [mrc_pkg::CountW-1:0]    cfg_wdata,
  // input words
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  // slot[4:0], base[68:5], size[132:69], region_type[140:133],
  // attributes[172:141], type_mask[204:173], zero fill up to 208 bits
  input  wire  [mrc_pkg::InDataW-1:0]   s_axis_tdata,
  // func[0]
  input  wire                           s_axis_tuser,
  // result words
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // covered[0], zero fill up to 8 bits
  output logic [mrc_pkg::OutDataW-1:0]  m_axis_tdata,
  // is_answer[0]
  output logic                          m_axis_tuser
);

  localparam int N = mrc_pkg::MaxRegions;

  // field offsets inside s_axis_tdata
  localparam int SlotLo = 0;
  localparam int BaseLo = SlotLo + mrc_pkg::SlotW;
  localparam int SizeLo = BaseLo + mrc_pkg::AddrW;
  localparam int TypeLo = SizeLo + mrc_pkg::AddrW;
  localparam int AttrLo = TypeLo + mrc_pkg::TypeW;
  localparam int MaskLo = AttrLo + mrc_pkg::AttrW;

  logic [mrc_pkg::CountW-1:0] region_count;

  // unpacked input fields
  logic [mrc_pkg::SlotW-1:0] in_slot;
  logic [mrc_pkg::AddrW-1:0] in_base;
  logic [mrc_pkg::AddrW-1:0] in_size;
  logic [mrc_pkg::TypeW-1:0] in_type;
  logic [mrc_pkg::AttrW-1:0] in_attrs;
  logic [mrc_pkg::MaskW-1:0] in_mask;

  logic [mrc_pkg::AddrW:0]   in_sum;     // base + size with carry
  logic                      span_ok;
  logic                      count_ok;
  mrc_pkg::item_t            front_next;

  // row of words: index 0 is the front stage, index k+1 the output of cell k
  logic           adv;
  logic           chain_valid [0:N];
  mrc_pkg::item_t chain_item  [0:N];

  assign in_slot  = s_axis_tdata[SlotLo +: mrc_pkg::SlotW];
  assign in_base  = s_axis_tdata[BaseLo +: mrc_pkg::AddrW];
  assign in_size  = s_axis_tdata[SizeLo +: mrc_pkg::AddrW];
  assign in_type  = s_axis_tdata[TypeLo +: mrc_pkg::TypeW];
  assign in_attrs = s_axis_tdata[AttrLo +: mrc_pkg::AttrW];
  assign in_mask  = s_axis_tdata[MaskLo +: mrc_pkg::MaskW];

  // a range is usable when nonempty and its end does not wrap
  assign in_sum   = {1'b0, in_base} + {1'b0, in_size};
  assign span_ok  = (in_size != '0) && !in_sum[mrc_pkg::AddrW];
  // a count past the table makes every query miss
  assign count_ok = mrc_pkg::CmpW'(region_count) <= mrc_pkg::CmpW'(N);

  always_comb begin
    front_next.query = (s_axis_tuser == mrc_pkg::FuncQuery);
    front_next.slot  = in_slot;
    front_next.base  = in_base;
    front_next.lim   = in_sum[mrc_pkg::AddrW-1:0];
    front_next.ok    = span_ok && (front_next.query ? count_ok : 1'b1);
    // types of 32 and up get no mask bit, so they only pass a zero mask
    if (mrc_pkg::TypeW'(mrc_pkg::MaskW) > in_type) begin
      front_next.type_bits = mrc_pkg::MaskW'(1) << in_type[mrc_pkg::TypeSelW-1:0];
    end else begin
      front_next.type_bits = '0;
    end
    front_next.attrs = in_attrs;
    front_next.mask  = in_mask;
    front_next.hit   = 1'b0;
  end

  // the whole row moves when the output register is free or being emptied
  assign adv           = !chain_valid[N] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= '0;
    end else if (cfg_wen) begin
      region_count <= cfg_wdata;
    end
  end

  // front stage
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else if (adv) begin
      chain_valid[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chain_item[0] <= front_next;
    end
  end

  // one cell per table entry
  for (genvar i = 0; i < N; i++) begin : g_cell
    mrc_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .adv          (adv),
      .idx          (mrc_pkg::IdxW'(i)),
      .region_count (region_count),
      .in_valid     (chain_valid[i]),
      .in_item      (chain_item[i]),
      .out_valid    (chain_valid[i+1]),
      .out_item     (chain_item[i+1])
    );
  end

  // last cell holds the result word
  assign m_axis_tvalid = chain_valid[N];
  assign m_axis_tuser  = chain_item[N].query;
  assign m_axis_tdata  = mrc_pkg::OutDataW'(chain_item[N].hit);

`ifndef SYNTHESIS
  // a write acknowledgement never reports a cover
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> !m_axis_tdata[0])
    else $error("write acknowledgement carries covered");

  // the row is empty right after reset
  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !chain_valid[0])
    else $error("word in flight after reset");

  // a query taken while the count is past the table can never hit
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser && !count_ok |=> !chain_item[0].ok)
    else $error("query with out-of-range count marked usable");
`endif

endmodule

`default_nettype wire
